// ----- rtl/afqm_pkg.sv -----
package afqm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int FMIX_W      = 4;
    localparam int MAXMIX_W    = 4;
    localparam int LIMIT_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int NSEL_W      = 5;

    // request commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_CAP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_TRIM_Q,
        ST_TICK_INIT,
        ST_RD,
        ST_ACC,
        ST_MUL,
        ST_EMIT,
        ST_POP,
        ST_TRIM_L
    } t_state;

    typedef struct packed {
        logic latch;
        logic clear;
        logic push_wr;
        logic trim;
        logic trim_lat;
        logic tick_init;
        logic rd_issue;
        logic mul;
        logic emit;
        logic pop;
    } t_ctl_cmd;

    typedef struct packed {
        logic push_close;
        logic n_zero;
        logic f_last;
        logic s_last;
        logic out_free;
    } t_dp_status;

    // ceil(2^24 / n): floor(m * recip >> 24) equals floor(m / n) for m below 2^20
    function automatic logic [RECIP_W-1:0] mix_recip(input logic [NSEL_W-1:0] n);
        case (n)
            5'd1:    return 25'd16777216;
            5'd2:    return 25'd8388608;
            5'd3:    return 25'd5592406;
            5'd4:    return 25'd4194304;
            5'd5:    return 25'd3355444;
            5'd6:    return 25'd2796203;
            5'd7:    return 25'd2396746;
            5'd8:    return 25'd2097152;
            5'd9:    return 25'd1864136;
            5'd10:   return 25'd1677722;
            5'd11:   return 25'd1525202;
            5'd12:   return 25'd1398102;
            5'd13:   return 25'd1290556;
            5'd14:   return 25'd1198373;
            5'd15:   return 25'd1118482;
            5'd16:   return 25'd1048576;
            default: return '0;
        endcase
    endfunction

endpackage

// ----- rtl/afqm_in_if.sv -----
interface afqm_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          cmd;
    logic signed [afqm_pkg::SAMPLE_W-1:0] sample_in;
    logic                                frame_end;

    modport source (output valid, cmd, sample_in, frame_end, input ready);
    modport sink   (input valid, cmd, sample_in, frame_end, output ready);
endinterface

// ----- rtl/afqm_out_if.sv -----
interface afqm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [afqm_pkg::SAMPLE_W-1:0] sample_out;
    logic                                last_of_frame;
    logic [afqm_pkg::FMIX_W-1:0]         frames_mixed;

    modport source (output valid, sample_out, last_of_frame, frames_mixed, input ready);
    modport sink   (input valid, sample_out, last_of_frame, frames_mixed, output ready);
endinterface

// ----- rtl/afqm_cfg_if.sv -----
interface afqm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [afqm_pkg::CFG_IDX_W-1:0]    index;
    logic [afqm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/afqm_ctrl.sv -----
module afqm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_in_cmd,
    output logic                  o_in_ready,
    input  afqm_pkg::t_dp_status  i_status,
    output afqm_pkg::t_ctl_cmd    o_cmd
);

    afqm_pkg::t_state r_state;
    afqm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afqm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            afqm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_in_cmd)
                        afqm_pkg::CMD_PUSH:  n_state = afqm_pkg::ST_PUSH;
                        afqm_pkg::CMD_TICK:  n_state = afqm_pkg::ST_TICK_INIT;
                        afqm_pkg::CMD_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            afqm_pkg::ST_PUSH: begin
                o_cmd.push_wr = 1'b1;
                n_state = i_status.push_close ? afqm_pkg::ST_TRIM_Q : afqm_pkg::ST_IDLE;
            end
            afqm_pkg::ST_TRIM_Q: begin
                o_cmd.trim = 1'b1;
                n_state    = afqm_pkg::ST_IDLE;
            end
            afqm_pkg::ST_TICK_INIT: begin
                o_cmd.tick_init = 1'b1;
                n_state         = afqm_pkg::ST_RD;
            end
            afqm_pkg::ST_RD: begin
                // silent frame: nothing to read
                if (i_status.n_zero) begin
                    n_state = afqm_pkg::ST_MUL;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_status.f_last) begin
                        n_state = afqm_pkg::ST_ACC;
                    end
                end
            end
            afqm_pkg::ST_ACC: begin
                n_state = afqm_pkg::ST_MUL;
            end
            afqm_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = afqm_pkg::ST_EMIT;
            end
            afqm_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.s_last) begin
                        n_state = afqm_pkg::ST_RD;
                    end else if (i_status.n_zero) begin
                        n_state = afqm_pkg::ST_IDLE;
                    end else begin
                        n_state = afqm_pkg::ST_POP;
                    end
                end
            end
            afqm_pkg::ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = afqm_pkg::ST_TRIM_L;
            end
            afqm_pkg::ST_TRIM_L: begin
                o_cmd.trim     = 1'b1;
                o_cmd.trim_lat = 1'b1;
                n_state        = afqm_pkg::ST_IDLE;
            end
            default: begin
                n_state = afqm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/afqm_dp.sv -----
module afqm_dp #(
    parameter int FRAME_SAMPLES = 64,
    parameter int QUEUE_DEPTH   = 16,
    parameter int MIX_MAX       = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  afqm_pkg::t_ctl_cmd                    i_cmd,
    output afqm_pkg::t_dp_status                  o_status,
    input  logic signed [afqm_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                  i_frame_end,
    input  logic [afqm_pkg::MAXMIX_W-1:0]         i_max_mix,
    input  logic [afqm_pkg::LIMIT_W-1:0]          i_queue_limit,
    input  logic [afqm_pkg::LIMIT_W-1:0]          i_latency_cap,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [afqm_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                  o_last_of_frame,
    output logic [afqm_pkg::FMIX_W-1:0]           o_frames_mixed
);

    localparam int SLOT_COUNT = QUEUE_DEPTH + 1;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 2);
    localparam int LEN_W      = $clog2(FRAME_SAMPLES + 1);
    localparam int ADDR_W     = $clog2(SLOT_COUNT * FRAME_SAMPLES);
    localparam int N_W        = $clog2(MIX_MAX + 1);
    localparam int ACC_W      = afqm_pkg::SAMPLE_W + $clog2(MIX_MAX);
    localparam int PROD_W     = ACC_W + afqm_pkg::RECIP_W;
    localparam int CMP_W      = (CNT_W > afqm_pkg::LIMIT_W) ? CNT_W : afqm_pkg::LIMIT_W;

    localparam logic [SLOT_W:0]         SLOTS_EXT = (SLOT_W + 1)'(SLOT_COUNT);
    localparam logic [CMP_W-1:0]        QD_EXT    = CMP_W'(QUEUE_DEPTH);
    localparam logic [CMP_W-1:0]        MIX_EXT   = CMP_W'(MIX_MAX);
    localparam logic signed [ACC_W:0]   SMAX      = (ACC_W + 1)'(32767);
    localparam logic signed [ACC_W:0]   SMIN      = (ACC_W + 1)'(-32768);

    logic [afqm_pkg::SAMPLE_W-1:0]        r_store [SLOT_COUNT * FRAME_SAMPLES];
    logic [LEN_W-1:0]                     r_len   [SLOT_COUNT];

    logic [SLOT_W-1:0]                    r_head;
    logic [CNT_W-1:0]                     r_queued;
    logic [LEN_W-1:0]                     r_fill;
    logic                                 r_rd_vld;
    logic                                 r_out_valid;

    logic signed [afqm_pkg::SAMPLE_W-1:0] r_sample;
    logic                                 r_frame_end;
    logic [N_W-1:0]                       r_n;
    logic [N_W-1:0]                       r_f;
    logic [LEN_W-1:0]                     r_s;
    logic [SLOT_W-1:0]                    r_rd_slot;
    logic signed [afqm_pkg::SAMPLE_W-1:0] r_rd_data;
    logic [LEN_W-1:0]                     r_rd_len;
    logic signed [ACC_W-1:0]              r_acc;
    logic [PROD_W-1:0]                    r_prod;
    logic                                 r_neg;
    logic signed [afqm_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                 r_out_last;
    logic [afqm_pkg::FMIX_W-1:0]          r_out_n;

    logic [SLOT_W-1:0]                    open_slot;
    logic [ADDR_W-1:0]                    wr_addr;
    logic [ADDR_W-1:0]                    rd_addr;
    logic [LEN_W-1:0]                     fill_eff;
    logic [LEN_W-1:0]                     fill_next;
    logic                                 push_close;
    logic [CMP_W-1:0]                     queued_ext;
    logic [CMP_W-1:0]                     lim_ext;
    logic [CMP_W-1:0]                     keep_ext;
    logic                                 trim_do;
    logic [SLOT_W-1:0]                    trim_head;
    logic [SLOT_W-1:0]                    pop_head;
    logic [SLOT_W-1:0]                    rd_slot_next;
    logic [CMP_W-1:0]                     n_sel;
    logic [ACC_W-1:0]                     mag;
    logic [ACC_W-1:0]                     quot;
    logic signed [ACC_W:0]                quot_s;
    logic signed [ACC_W:0]                mixed;
    logic signed [ACC_W:0]                mixed_sat;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] v);
        logic [SLOT_W:0] t;
        t = (v >= SLOTS_EXT) ? v - SLOTS_EXT : v;
        return t[SLOT_W-1:0];
    endfunction

    always_comb begin
        // the open frame sits in the slot right after the queue tail
        open_slot  = wrap_slot((SLOT_W + 1)'(r_head) + (SLOT_W + 1)'(r_queued));
        fill_eff   = (r_fill >= LEN_W'(FRAME_SAMPLES)) ? '0 : r_fill;
        fill_next  = fill_eff + LEN_W'(1);
        push_close = (fill_next == LEN_W'(FRAME_SAMPLES)) || r_frame_end;
        wr_addr    = ADDR_W'(open_slot) * ADDR_W'(FRAME_SAMPLES) + ADDR_W'(fill_eff);
        rd_addr    = ADDR_W'(r_rd_slot) * ADDR_W'(FRAME_SAMPLES) + ADDR_W'(r_s);

        queued_ext = CMP_W'(r_queued);
        lim_ext    = (CMP_W'(i_queue_limit) > QD_EXT) ? QD_EXT : CMP_W'(i_queue_limit);
        keep_ext   = i_cmd.trim_lat ? CMP_W'(i_latency_cap) : lim_ext;
        trim_do    = queued_ext > keep_ext;
        trim_head  = wrap_slot((SLOT_W + 1)'(r_head) + (SLOT_W + 1)'(queued_ext - keep_ext));
        pop_head   = wrap_slot((SLOT_W + 1)'(r_head) + (SLOT_W + 1)'(r_n));
        rd_slot_next = wrap_slot((SLOT_W + 1)'(r_rd_slot) + (SLOT_W + 1)'(1));

        n_sel = CMP_W'(i_max_mix);
        if (n_sel == '0) begin
            n_sel = CMP_W'(1);
        end
        if (n_sel > MIX_EXT) begin
            n_sel = MIX_EXT;
        end
        if (n_sel > queued_ext) begin
            n_sel = queued_ext;
        end

        mag       = r_acc[ACC_W-1] ? $unsigned(-r_acc) : $unsigned(r_acc);
        quot      = r_prod[afqm_pkg::RECIP_SHIFT +: ACC_W];
        quot_s    = $signed({1'b0, quot});
        mixed     = r_neg ? -quot_s : quot_s;
        mixed_sat = (mixed > SMAX) ? SMAX : ((mixed < SMIN) ? SMIN : mixed);
    end

    always_comb begin
        o_status.push_close = push_close;
        o_status.n_zero     = (r_n == '0);
        o_status.f_last     = (r_f == r_n - N_W'(1));
        o_status.s_last     = (r_s == LEN_W'(FRAME_SAMPLES - 1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // frame memories, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_store[wr_addr] <= r_sample;
            if (push_close) begin
                r_len[open_slot] <= fill_next;
            end
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_store[rd_addr];
            r_rd_len  <= r_len[r_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_queued    <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_queued <= '0;
                r_fill   <= '0;
            end
            if (i_cmd.push_wr) begin
                if (push_close) begin
                    r_fill   <= '0;
                    r_queued <= r_queued + CNT_W'(1);
                end else begin
                    r_fill <= fill_next;
                end
            end
            // drop the oldest frames down to the kept length
            if (i_cmd.trim && trim_do) begin
                r_head   <= trim_head;
                r_queued <= CNT_W'(keep_ext);
            end
            if (i_cmd.pop) begin
                r_head   <= pop_head;
                r_queued <= r_queued - CNT_W'(r_n);
            end
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sample    <= i_sample;
            r_frame_end <= i_frame_end;
        end
        if (i_cmd.tick_init) begin
            r_n       <= N_W'(n_sel);
            r_s       <= '0;
            r_f       <= '0;
            r_rd_slot <= r_head;
            r_acc     <= '0;
        end
        if (i_cmd.rd_issue) begin
            r_f       <= r_f + N_W'(1);
            r_rd_slot <= rd_slot_next;
        end
        // samples past a short frame's length count as zero
        if (r_rd_vld && (r_s < r_rd_len)) begin
            r_acc <= r_acc + ACC_W'(r_rd_data);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(mag) *
                      PROD_W'(afqm_pkg::mix_recip(afqm_pkg::NSEL_W'(r_n)));
            r_neg  <= r_acc[ACC_W-1];
        end
        if (i_cmd.emit) begin
            r_out_sample <= mixed_sat[afqm_pkg::SAMPLE_W-1:0];
            r_out_last   <= o_status.s_last;
            r_out_n      <= afqm_pkg::FMIX_W'(r_n);
            r_s          <= r_s + LEN_W'(1);
            r_f          <= '0;
            r_rd_slot    <= r_head;
            r_acc        <= '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_out_sample;
    assign o_last_of_frame = r_out_last;
    assign o_frames_mixed  = r_out_n;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_queued == '0) && (r_fill == '0))
        else $error("queue not empty after clear");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < LEN_W'(FRAME_SAMPLES))
        else $error("open frame fill out of range");

    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_n != '0) && (r_f < r_n))
        else $error("frame read past mix count");

    a_trim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.trim |=> (CMP_W'(r_queued) <= $past(keep_ext)))
        else $error("queue longer than kept length after trim");

endmodule

// ----- rtl/audio_frame_queue_mixer.sv -----
// Averaging mixer for queued remote audio frames.
// i_in carries requests: cmd push appends sample_in to the open frame (frame_end
// or a full frame of FRAME_SAMPLES closes it, then the oldest frames are dropped
// down to queue_limit), cmd tick plays one frame, cmd clear empties the queue.
// A tick returns FRAME_SAMPLES results on o_out, each the average of up to
// max_mix head frames (truncated toward zero), last_of_frame on the final one,
// frames_mixed 0 and silence when the queue is empty; the mixed frames are then
// popped and the queue is trimmed to latency_cap.
// i_cfg writes max_mix (index 0), queue_limit (1) and latency_cap (2); it is
// always ready; the user must write it only while the block is idle, which the
// block does not enforce. A push passes the push state, and the trim state too
// when it closes a frame; clear is done in the idle state that accepts it. A
// tick initialises, then for each sample reads and sums the mixed frames
// through the single read port of the frame store, one frame's sample per cycle
// (none for a silent frame), then a reciprocal multiply and the output register.
// A stalled receiver holds the output register and the sequencer waits on it;
// the next request is taken while the final result still waits.
// Reset empties the queue and restores max_mix 4, queue_limit 16, latency_cap 4.
module audio_frame_queue_mixer #(
    parameter int FRAME_SAMPLES = 64,
    parameter int QUEUE_DEPTH   = 16,
    parameter int MIX_MAX       = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    afqm_in_if.sink      i_in,
    afqm_out_if.source   o_out,
    afqm_cfg_if.sink     i_cfg
);

    logic [afqm_pkg::MAXMIX_W-1:0] r_max_mix;
    logic [afqm_pkg::LIMIT_W-1:0]  r_queue_limit;
    logic [afqm_pkg::LIMIT_W-1:0]  r_latency_cap;

    afqm_pkg::t_ctl_cmd            ctl_cmd;
    afqm_pkg::t_dp_status          dp_status;
    logic                          in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mix     <= afqm_pkg::MAXMIX_W'(4);
            r_queue_limit <= afqm_pkg::LIMIT_W'(16);
            r_latency_cap <= afqm_pkg::LIMIT_W'(4);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                afqm_pkg::CFG_MAX_MIX:     r_max_mix     <= i_cfg.data[afqm_pkg::MAXMIX_W-1:0];
                afqm_pkg::CFG_QUEUE_LIMIT: r_queue_limit <= i_cfg.data;
                afqm_pkg::CFG_LATENCY_CAP: r_latency_cap <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    afqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    afqm_dp #(
        .FRAME_SAMPLES (FRAME_SAMPLES),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .MIX_MAX       (MIX_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_status        (dp_status),
        .i_sample        (i_in.sample_in),
        .i_frame_end     (i_in.frame_end),
        .i_max_mix       (r_max_mix),
        .i_queue_limit   (r_queue_limit),
        .i_latency_cap   (r_latency_cap),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_sample_out    (o_out.sample_out),
        .o_last_of_frame (o_out.last_of_frame),
        .o_frames_mixed  (o_out.frames_mixed)
    );

endmodule
